### rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache table
// Sizes, request and response payload structs, and operation codes.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // entry index and recency rank share the same width
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W  = IDX_W;
    // occupancy count, able to hold ENTRIES itself
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    // common width for comparing occupancy against capacity
    localparam int OCC_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]      CAP_RESET  = CAP_W'(16);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_INIT = COUNT_BITS'(1);
    localparam logic [DATA_W-1:0]     READ_MISS  = '1;
    localparam logic [DATA_W-1:0]     READ_PUT   = '0;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } rsp_t;

endpackage

### rtl/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table: key-value cache with LFU replacement and LRU tie-break
// One request at a time; a single key/victim compare unit walks the table.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  req     | in        | req_valid/req_ready | req_t  {func, key, value}
//  rsp     | out       | rsp_valid/rsp_ready | rsp_t  {hit, read_value}
//  cfg     | in        | cfg_we (no wait)    | cfg_wdata = capacity_in_use
//
//  A request is accepted in idle, then scans all ENTRIES (16) entries one
//  entry per cycle through the shared key and victim comparator, and then
//  updates the table and loads the response register.
//  Reset empties the table and sets capacity to 16; no clearing pass is needed
//  because only the per-entry valid bits are cleared.
//  A stalled response holds in its register; a new request is still accepted,
//  and its update cycle waits until the response register is free.
//
module lfu_cache_table
    import lfu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,

    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,

    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    state_t             state_reg,     state_next;
    logic [CAP_W-1:0]   cap_reg,       cap_next;
    logic [ENTRIES-1:0] valid_reg,     valid_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // ------------------------------------------------------------------------
    // Table storage (payload, no reset)
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0]      key_reg  [ENTRIES];
    logic [KEY_W-1:0]      key_next [ENTRIES];
    logic [DATA_W-1:0]     data_reg [ENTRIES];
    logic [DATA_W-1:0]     data_next[ENTRIES];
    logic [COUNT_BITS-1:0] uses_reg [ENTRIES];
    logic [COUNT_BITS-1:0] uses_next[ENTRIES];
    logic [AGE_W-1:0]      age_reg  [ENTRIES];
    logic [AGE_W-1:0]      age_next [ENTRIES];

    // ------------------------------------------------------------------------
    // Request latch and scan results
    // ------------------------------------------------------------------------
    req_t                  req_reg,        req_next;
    rsp_t                  rsp_reg,        rsp_next;
    logic [IDX_W-1:0]      scan_idx_reg,   scan_idx_next;
    logic [CNT_W-1:0]      used_reg,       used_next;

    logic                  found_reg,      found_next;
    logic [IDX_W-1:0]      found_idx_reg,  found_idx_next;
    logic [AGE_W-1:0]      found_age_reg,  found_age_next;
    logic [COUNT_BITS-1:0] found_uses_reg, found_uses_next;

    logic                  vict_reg,       vict_next;
    logic [IDX_W-1:0]      vict_idx_reg,   vict_idx_next;
    logic [AGE_W-1:0]      vict_age_reg,   vict_age_next;
    logic [COUNT_BITS-1:0] vict_uses_reg,  vict_uses_next;

    logic                  free_reg,       free_next;
    logic [IDX_W-1:0]      free_idx_reg,   free_idx_next;

    // ------------------------------------------------------------------------
    // Shared compare unit: one table entry per cycle
    // ------------------------------------------------------------------------
    logic                  scan_valid;
    logic [KEY_W-1:0]      scan_key;
    logic [COUNT_BITS-1:0] scan_uses;
    logic [AGE_W-1:0]      scan_age;
    logic                  scan_match;
    logic                  scan_better;
    logic                  scan_last;

    assign scan_valid  = valid_reg[scan_idx_reg];
    assign scan_key    = key_reg[scan_idx_reg];
    assign scan_uses   = uses_reg[scan_idx_reg];
    assign scan_age    = age_reg[scan_idx_reg];
    assign scan_match  = scan_valid && (scan_key == req_reg.key);
    // lower count wins; on a tie the older entry (larger rank) wins
    assign scan_better = !vict_reg || (scan_uses < vict_uses_reg) ||
                         ((scan_uses == vict_uses_reg) && (scan_age > vict_age_reg));
    assign scan_last   = (scan_idx_reg == IDX_W'(ENTRIES - 1));

    // ------------------------------------------------------------------------
    // Update decisions
    // ------------------------------------------------------------------------
    logic [OCC_W-1:0] cap_eff;
    logic             do_apply;
    logic             is_put;
    logic             touch_en;
    logic             evict_en;
    logic             ins_en;
    logic [IDX_W-1:0] ins_idx;

    // capacity above the table size behaves as the table size
    assign cap_eff  = (OCC_W'(cap_reg) > OCC_W'(ENTRIES)) ? OCC_W'(ENTRIES)
                                                          : OCC_W'(cap_reg);
    assign do_apply = (state_reg == ST_APPLY) && (!rsp_valid_reg || rsp_ready);
    assign is_put   = (req_reg.func == FUNC_PUT);

    always_comb
    begin
        touch_en = 1'b0;
        evict_en = 1'b0;
        ins_en   = 1'b0;
        ins_idx  = free_idx_reg;
        if (!is_put)
        begin
            touch_en = found_reg;
        end
        else if (cap_eff != '0)
        begin
            if (found_reg)
            begin
                touch_en = 1'b1;
            end
            else
            begin
                // table full: drop the victim and reuse its slot
                evict_en = (OCC_W'(used_reg) >= cap_eff) && vict_reg;
                ins_en   = evict_en || free_reg;
                ins_idx  = evict_en ? vict_idx_reg : free_idx_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        valid_next      = valid_reg;
        rsp_valid_next  = rsp_valid_reg;
        key_next        = key_reg;
        data_next       = data_reg;
        uses_next       = uses_reg;
        age_next        = age_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        scan_idx_next   = scan_idx_reg;
        used_next       = used_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_age_next  = found_age_reg;
        found_uses_next = found_uses_reg;
        vict_next       = vict_reg;
        vict_idx_next   = vict_idx_reg;
        vict_age_next   = vict_age_reg;
        vict_uses_next  = vict_uses_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    // latch the request and restart the scan
                    req_next      = req;
                    scan_idx_next = '0;
                    used_next     = '0;
                    found_next    = 1'b0;
                    vict_next     = 1'b0;
                    free_next     = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (scan_valid)
                begin
                    used_next = used_reg + CNT_W'(1);
                    if (scan_match)
                    begin
                        found_next      = 1'b1;
                        found_idx_next  = scan_idx_reg;
                        found_age_next  = scan_age;
                        found_uses_next = scan_uses;
                    end
                    if (scan_better)
                    begin
                        vict_next      = 1'b1;
                        vict_idx_next  = scan_idx_reg;
                        vict_age_next  = scan_age;
                        vict_uses_next = scan_uses;
                    end
                end
                else if (!free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = scan_idx_reg;
                end
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_last)
                begin
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY:
            begin
                if (do_apply)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;

                    // response
                    if (is_put)
                    begin
                        rsp_next.hit        = found_reg && (cap_eff != '0);
                        rsp_next.read_value = READ_PUT;
                    end
                    else
                    begin
                        rsp_next.hit        = found_reg;
                        rsp_next.read_value = found_reg ? data_reg[found_idx_reg] : READ_MISS;
                    end

                    // hit: raise the count and move the entry to the front
                    if (touch_en)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (valid_reg[i] && (IDX_W'(i) != found_idx_reg) &&
                                (age_reg[i] < found_age_reg))
                            begin
                                age_next[i] = age_reg[i] + AGE_W'(1);
                            end
                        end
                        age_next[found_idx_reg] = '0;
                        if (found_uses_reg != COUNT_MAX)
                        begin
                            uses_next[found_idx_reg] = found_uses_reg + COUNT_BITS'(1);
                        end
                        if (is_put)
                        begin
                            data_next[found_idx_reg] = req_reg.value;
                        end
                    end

                    // miss on put: close the victim's rank gap, age the rest, insert
                    if (ins_en)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (valid_reg[i] && !(evict_en && (IDX_W'(i) == vict_idx_reg)))
                            begin
                                if (!(evict_en && (age_reg[i] > vict_age_reg)))
                                begin
                                    age_next[i] = age_reg[i] + AGE_W'(1);
                                end
                            end
                        end
                        valid_next[ins_idx] = 1'b1;
                        key_next[ins_idx]   = req_reg.key;
                        data_next[ins_idx]  = req_reg.value;
                        uses_next[ins_idx]  = COUNT_INIT;
                        age_next[ins_idx]   = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write empties the table
        if (cfg_we)
        begin
            cap_next   = cfg_wdata;
            valid_next = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        data_reg       <= data_next;
        uses_reg       <= uses_next;
        age_reg        <= age_next;
        req_reg        <= req_next;
        rsp_reg        <= rsp_next;
        scan_idx_reg   <= scan_idx_next;
        used_reg       <= used_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        found_age_reg  <= found_age_next;
        found_uses_reg <= found_uses_next;
        vict_reg       <= vict_next;
        vict_idx_reg   <= vict_idx_next;
        vict_age_reg   <= vict_age_next;
        vict_uses_reg  <= vict_uses_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### verif/lfu_cache_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_table_checker: response predictor and scoreboard
// Watches the request, response and capacity ports of the cache table, keeps
// its own copy of the table and compares every response with the prediction.
// ----------------------------------------------------------------------------
module lfu_cache_table_checker
    import lfu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  req_t             req,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    output int               fail_count,
    output int               pending,
    output int               hit_count,
    output int               evict_count
);

    logic                  slot_used [ENTRIES];
    logic [KEY_W-1:0]      slot_key  [ENTRIES];
    logic [DATA_W-1:0]     slot_data [ENTRIES];
    logic [COUNT_BITS-1:0] slot_uses [ENTRIES];
    logic [AGE_W-1:0]      slot_age  [ENTRIES];
    logic [CAP_W-1:0]      capacity;

    rsp_t expected_rsps [$];
    int   errs   = 0;
    int   hits   = 0;
    int   evicts = 0;

    assign fail_count  = errs;
    assign hit_count   = hits;
    assign evict_count = evicts;

    // make slot s the most recent; younger slots age by one
    function automatic void promote(input int s);
        logic [AGE_W-1:0] was;
        was = slot_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && i != s && slot_age[i] < was)
                slot_age[i] = slot_age[i] + 1'b1;
        slot_age[s] = '0;
        if (slot_uses[s] != COUNT_MAX)
            slot_uses[s] = slot_uses[s] + 1'b1;
    endfunction

    function automatic rsp_t cache_access(input req_t r);
        rsp_t             res;
        int               found;
        int               victim;
        int               free_slot;
        int               occupied;
        int               limit;
        logic [AGE_W-1:0] gone;
        found     = -1;
        victim    = -1;
        free_slot = -1;
        occupied  = 0;
        limit     = (capacity > ENTRIES) ? ENTRIES : int'(capacity);

        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i]) begin
                occupied++;
                if (slot_key[i] == r.key)
                    found = i;
                if (victim < 0 || slot_uses[i] < slot_uses[victim]
                    || (slot_uses[i] == slot_uses[victim]
                        && slot_age[i] > slot_age[victim]))
                    victim = i;
            end
            else if (free_slot < 0) begin
                free_slot = i;
            end
        end

        if (r.func == FUNC_GET) begin
            if (found >= 0) begin
                res.hit        = 1'b1;
                res.read_value = slot_data[found];
                promote(found);
            end
            else begin
                res.hit        = 1'b0;
                res.read_value = READ_MISS;
            end
            return res;
        end

        res.hit        = 1'b0;
        res.read_value = READ_PUT;
        if (limit == 0)
            return res;
        if (found >= 0) begin
            res.hit          = 1'b1;
            slot_data[found] = r.value;
            promote(found);
            return res;
        end

        // full: drop the least used, oldest on a tie
        if (occupied >= limit && victim >= 0) begin
            gone              = slot_age[victim];
            slot_used[victim] = 1'b0;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_age[i] > gone)
                    slot_age[i] = slot_age[i] - 1'b1;
            free_slot = victim;
            evicts++;
        end
        if (free_slot < 0)
            return res;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i])
                slot_age[i] = slot_age[i] + 1'b1;
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot]  = r.key;
        slot_data[free_slot] = r.value;
        slot_uses[free_slot] = COUNT_INIT;
        slot_age[free_slot]  = '0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                slot_used[i] = 1'b0;
            capacity = CAP_RESET;
            expected_rsps.delete();
            pending <= 0;
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response: hit %0b read_value %h",
                           rsp.hit, rsp.read_value);
                    errs++;
                end
                else begin
                    want = expected_rsps.pop_front();
                    if (rsp.hit !== want.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, rsp.hit);
                        errs++;
                    end
                    if (rsp.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, rsp.read_value);
                        errs++;
                    end
                end
            end
            if (cfg_we) begin
                capacity = cfg_wdata;
                for (int i = 0; i < ENTRIES; i++)
                    slot_used[i] = 1'b0;
            end
            if (req_valid && req_ready) begin
                want = cache_access(req);
                if (want.hit)
                    hits++;
                expected_rsps.push_back(want);
            end
            pending <= expected_rsps.size();
        end
    end

endmodule

### verif/lfu_cache_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_table_tb: stimulus and verdict for the LFU cache table
// Drives directed and random get/put requests over several capacity settings,
// stalls both channels at random, and leaves checking to the checker module.
// ----------------------------------------------------------------------------
module lfu_cache_table_tb;
    import lfu_pkg::*;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int LONG_HOLD     = 150;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 65;
    localparam int POOL_SIZE     = 24;
    localparam int SETTLE_CYCLES = 40;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    req_t             req       = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    rsp_t             rsp;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int hit_count;
    int evict_count;

    // shared between the sender and the response-side process
    bit idle_en     = 1'b0;
    int holds_asked = 0;
    int holds_done  = 0;

    int sent = 0;
    int cycles = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int phase_caps [RANDOM_PHASES] = '{1, 4, 16, 31, 17, 0, 8, 3, 16, 2};

    lfu_cache_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lfu_cache_table_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .hit_count   (hit_count),
        .evict_count (evict_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Response side: mostly ready, with random stall bursts while idling is
    // enabled, and one long hold-off whenever the sender asks for it.
    initial
    begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (holds_asked != holds_done) begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
                rsp_ready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 5) == 0) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until the block takes it. Valid is only
    // lowered in the optional gap before the request, never in the same step
    // that raises it again.
    task automatic issue_request(input logic f, input logic [KEY_W-1:0] k,
                                 input logic [DATA_W-1:0] v);
        req_t item;
        item.func  = f;
        item.key   = k;
        item.value = v;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent++;
    endtask

    // Drop valid and wait until every predicted response has been taken.
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Only called right after wait_for_responses, so the block is idle and
    // cfg_we never gets two updates in one step.
    task automatic write_capacity(input logic [CAP_W-1:0] c);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int n_directed;
        int lim;
        logic             f;
        logic [KEY_W-1:0] k;
        logic [DATA_W-1:0] v;

        // small key pool so that gets and puts keep hitting; extremes first
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'h8000_0000;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_en = 1'b1;

        // Reset capacity: empty-table miss, extreme keys and values, a stored
        // value of all ones that must still report a hit, and an overwrite.
        issue_request(FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        issue_request(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        issue_request(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        issue_request(FUNC_GET, 32'h8000_0000, 32'h1234_5678);
        issue_request(FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(FUNC_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
        issue_request(FUNC_GET, 32'h0000_0000, 32'hA5A5_A5A5);
        wait_for_responses();

        // Two entries: the least used entry goes first.
        write_capacity(CAP_W'(2));
        issue_request(FUNC_PUT, 32'h11, 32'hAAAA_0001);
        issue_request(FUNC_PUT, 32'h22, 32'hBBBB_0002);
        issue_request(FUNC_GET, 32'h11, 32'h0);
        issue_request(FUNC_PUT, 32'h33, 32'hCCCC_0003);
        issue_request(FUNC_GET, 32'h22, 32'h0);
        issue_request(FUNC_PUT, 32'h44, 32'hDDDD_0004);
        wait_for_responses();

        // Rewrite the same capacity: table must come back empty, then equal
        // counts fall back to the oldest entry.
        write_capacity(CAP_W'(2));
        issue_request(FUNC_GET, 32'h11, 32'h0);
        issue_request(FUNC_PUT, 32'h55, 32'h0000_0055);
        issue_request(FUNC_PUT, 32'h66, 32'h0000_0066);
        issue_request(FUNC_PUT, 32'h77, 32'h0000_0077);
        issue_request(FUNC_GET, 32'h55, 32'h0);
        issue_request(FUNC_GET, 32'h66, 32'h0);
        wait_for_responses();

        // Zero capacity: puts are dropped, gets miss.
        write_capacity(CAP_W'(0));
        issue_request(FUNC_PUT, 32'h88, 32'h0000_0088);
        issue_request(FUNC_GET, 32'h88, 32'h0);
        wait_for_responses();
        n_directed = sent;

        // Random phases, one capacity each. Phase 4 and the last two run
        // without idling; phase 2 starts with a long response hold-off so the
        // request side backs up.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_en = (p != 4) && (p < RANDOM_PHASES - 2);
            write_capacity(CAP_W'(phase_caps[p]));
            lim = (phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p];
            if (p == 2)
                holds_asked++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                f = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 7) == 0)
                    k = $urandom;
                else
                    k = key_pool[$urandom_range(0, lim + 3)];
                case ($urandom_range(0, 9))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
                issue_request(f, k, v);
            end
            wait_for_responses();
        end

        // let anything stray surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d requests (%0d directed, %0d random),",
                 sent, n_directed, sent - n_directed);
        $display("summary: %0d hits, %0d evictions, capacities 0 to 31, one %0d-cycle stall",
                 hit_count, evict_count, LONG_HOLD);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
rtl/lfu_pkg.sv
rtl/lfu_cache_table.sv
verif/lfu_cache_table_checker.sv
verif/lfu_cache_table_tb.sv
